// ----- rtl/strict_decimal_int64_parser_assert.svh -----
// Assertion macros for the strict decimal int64 parser.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef STRICT_DECIMAL_INT64_PARSER_ASSERT_SVH
`define STRICT_DECIMAL_INT64_PARSER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define SDIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define SDIP_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/sdip_pkg.sv -----
// Shared types and constants for the strict decimal int64 parser.
// No dependencies; imported by sdip_step and strict_decimal_int64_parser.
package sdip_pkg;

  localparam int unsigned MagW = 64;

  // Parse phase codes
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_SIGN  = 3'd1;
  localparam logic [2:0] PH_DIGIT = 3'd2;
  localparam logic [2:0] PH_TRAIL = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXPECTED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Magnitude saturates at 2^63
  localparam logic [MagW-1:0] MAG_LIMIT = {1'b1, {(MagW-1){1'b0}}};

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [2:0]      phase;
    logic            negative;
    logic [MagW-1:0] magnitude;
    logic            range_exceeded;
    logic            nul_seen;
  } sdip_state_t;

  localparam sdip_state_t STATE_RESET = '{
    phase:          PH_LEAD,
    negative:       1'b0,
    magnitude:      '0,
    range_exceeded: 1'b0,
    nul_seen:       1'b0
  };

  typedef struct packed {
    logic [MagW-1:0] value;
    logic [1:0]      status;
  } sdip_result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

endpackage

// ----- rtl/sdip_step.sv -----
// Next-state and result logic of the parser for one byte.
// Depends on sdip_pkg.
module sdip_step (
  input  sdip_pkg::sdip_state_t  state_i,
  input  logic [7:0]             text_byte_i,
  input  logic                   empty_text_i,
  output sdip_pkg::sdip_state_t  state_o,
  output sdip_pkg::sdip_result_t result_o
);
  import sdip_pkg::*;

  logic [MagW+3:0] mag_ext;
  logic [MagW+3:0] mag_next;
  logic            is_digit;
  logic            ws;

  assign mag_ext  = {4'b0000, state_i.magnitude};
  // magnitude * 10 + digit, with spare bits so the bound test is exact
  assign mag_next = (mag_ext << 3) + (mag_ext << 1) + {{MagW{1'b0}}, text_byte_i[3:0]};
  assign is_digit = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);
  assign ws       = is_ws(text_byte_i);

  always_comb begin
    sdip_state_t nxt;
    logic        take;
    nxt  = state_i;
    take = 1'b0;
    if (!empty_text_i) begin
      if (text_byte_i == CH_NUL) begin
        nxt.nul_seen = 1'b1;
      end
      case (state_i.phase)
        PH_LEAD: begin
          if (ws) begin
            nxt.phase = PH_LEAD;
          end else if ((text_byte_i == CH_PLUS) || (text_byte_i == CH_MINUS)) begin
            nxt.negative = (text_byte_i == CH_MINUS);
            nxt.phase    = PH_SIGN;
          end else if (is_digit) begin
            take      = 1'b1;
            nxt.phase = PH_DIGIT;
          end else begin
            nxt.phase = PH_ERR;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            take      = 1'b1;
            nxt.phase = PH_DIGIT;
          end else begin
            nxt.phase = PH_ERR;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            take = 1'b1;
          end else if (ws) begin
            nxt.phase = PH_TRAIL;
          end else begin
            nxt.phase = PH_ERR;
          end
        end
        PH_TRAIL: begin
          if (!ws) begin
            nxt.phase = PH_ERR;
          end
        end
        default: begin
          nxt.phase = PH_ERR;
        end
      endcase
      // Saturate once the run leaves range; later digits are dropped
      if (take && !state_i.range_exceeded) begin
        if (mag_next > {4'b0000, MAG_LIMIT}) begin
          nxt.range_exceeded = 1'b1;
          nxt.magnitude      = MAG_LIMIT;
        end else begin
          nxt.magnitude = mag_next[MagW-1:0];
        end
      end
    end
    state_o = nxt;
  end

  always_comb begin
    result_o.value  = '0;
    result_o.status = ST_EXPECTED;
    if (state_o.nul_seen) begin
      result_o.status = ST_EXPECTED;
    end else if (state_o.range_exceeded ||
                 (!state_o.negative && (state_o.magnitude == MAG_LIMIT))) begin
      result_o.status = ST_OVERFLOW;
    end else if ((state_o.phase == PH_DIGIT) || (state_o.phase == PH_TRAIL)) begin
      result_o.status = ST_OK;
      result_o.value  = state_o.negative ? ({MagW{1'b0}} - state_o.magnitude)
                                         : state_o.magnitude;
    end
  end

endmodule

// ----- rtl/strict_decimal_int64_parser.sv -----
// Top level of the strict decimal int64 parser: input register, parse state, result register.
// Depends on sdip_pkg, sdip_step and strict_decimal_int64_parser_assert.svh.
//
//   channel  | dir | tdata                         | side band
//   ---------+-----+-------------------------------+------------------------------
//   s_axis   | in  | [7:0] text_byte               | tlast last_byte, tuser empty_text
//   m_axis   | out | [63:0] value, [65:64] status  | none (one item per string)
//
// One byte item per cycle unless a string end waits on a busy result register; a result
// item passes the input register, then the result register, after its string's last byte.
// The parse state loop (multiply by ten, add, bound compare) is combinational.
// Reset clears the parse state and both valid flags; the parser then waits for the
// first byte of a string.
// A stalled result register holds only items that end a string: bytes in the middle of
// a string keep flowing, and the input register stalls on a string end meanwhile.
module strict_decimal_int64_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // last_byte
  input  logic        s_axis_tuser_i,   // empty_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [63:0] value, [65:64] status, [71:66] zero
);
  import sdip_pkg::*;

  // Input register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        in_empty_q;

  // Parse state
  sdip_state_t state_q, state_d;
  sdip_state_t state_step;

  // Result register
  logic         out_valid_q, out_valid_d;
  sdip_result_t out_q, out_d;
  sdip_result_t result_step;

  logic ends;
  logic out_free;
  logic consume;
  logic accept;

  assign ends     = in_last_q || in_empty_q;
  assign out_free = !out_valid_q || m_axis_tready_i;
  // Advance the held byte unless it ends a string and the result slot is busy
  assign consume  = in_valid_q && (!ends || out_free);
  assign s_axis_tready_o = !in_valid_q || consume;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  sdip_step u_step (
    .state_i      (state_q),
    .text_byte_i  (in_byte_q),
    .empty_text_i (in_empty_q),
    .state_o      (state_step),
    .result_o     (result_step)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    if (consume) begin
      // Return to the start state once a string ends
      state_d = ends ? STATE_RESET : state_step;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (consume && ends) begin
      out_valid_d = 1'b1;
      out_d       = result_step;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= s_axis_tdata_i;
      in_last_q  <= s_axis_tlast_i;
      in_empty_q <= s_axis_tuser_i;
    end
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_q.status, out_q.value};

  // Assertions
`include "strict_decimal_int64_parser_assert.svh"

  `SDIP_ASSERT(a_mag_bound, (state_q.magnitude <= MAG_LIMIT), "magnitude above 2^63")
  `SDIP_ASSERT(a_sat_mag, (!state_q.range_exceeded || (state_q.magnitude == MAG_LIMIT)), "overflow flag without saturated magnitude")
  `SDIP_ASSERT(a_value_ok, (!out_valid_q || (out_q.status == ST_OK) || (out_q.value == '0)), "nonzero value with error status")
  `SDIP_ASSERT_NEXT(a_reset_after_end, (consume && ends), ((state_q.phase == PH_LEAD) && (state_q.magnitude == '0) && m_axis_tvalid_o), "state not cleared after string end")

endmodule
